@@ hdl/sfa_pkg.sv @@
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared widths, register indexes, the CORDIC angle table and the lane type
// that travels along the row of rotation cells.
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int DEF_MAX_PARTICLES = 8192;
    localparam int DEF_POSITION_BITS = 24;
    localparam int DEF_CORDIC_STAGES = 18;

    localparam int POS_W       = 24;
    localparam int HARM_W      = 8;
    localparam int IN_TDATA_W  = 72;
    localparam int SF_W        = 30;
    localparam int PCOUNT_W    = 14;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int TURN_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_Z = 2'd2;

    localparam logic [HARM_W-1:0] HARMONIC_RESET = 8'd1;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    localparam int CX_W       = 34;
    localparam int CZ_W       = 33;
    localparam int UNIT_W     = 18;
    localparam int UNIT_SHIFT = 14;
    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_TABLE_LEN = 24;

    localparam logic signed [CX_W-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [ANGLE_TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic [1:0]             quad;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } cordic_lane_t;

endpackage

@@ hdl/sfa_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// sfa_cordic_cell
// One rotation-mode CORDIC stage; registers its lane for the next cell.
// ----------------------------------------------------------------------------
module sfa_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfa_pkg::cordic_lane_t lane_in,
    output sfa_pkg::cordic_lane_t lane_out
);
    import sfa_pkg::*;

    localparam logic signed [CZ_W-1:0] ANGLE = CZ_W'(ATAN_TURNS[STAGE]);

    cordic_lane_t lane_reg;
    cordic_lane_t lane_next;

    always_comb
    begin
        lane_next = lane_in;
        if (!lane_in.z[CZ_W-1])
        begin
            lane_next.x = lane_in.x - (lane_in.y >>> STAGE);
            lane_next.y = lane_in.y + (lane_in.x >>> STAGE);
            lane_next.z = lane_in.z - ANGLE;
        end
        else
        begin
            lane_next.x = lane_in.x + (lane_in.y >>> STAGE);
            lane_next.y = lane_in.y - (lane_in.x >>> STAGE);
            lane_next.z = lane_in.z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

@@ hdl/sfa_divider.sv @@
// ----------------------------------------------------------------------------
// sfa_divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfa_divider #(
    parameter int N_W = 45,
    parameter int D_W = 14
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!diff[D_W])
                begin
                    rem_reg <= diff[D_W-1:0];
                    quo_reg <= {quo_reg[N_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[D_W-1:0];
                    quo_reg <= {quo_reg[N_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/structure_factor_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// structure_factor_accumulator_unit
// Static structure factor for one wave vector over a streamed particle set.
// ----------------------------------------------------------------------------
// Positions arrive on the s_axis channel, one particle per transfer, with
// tlast on the final particle of a set. The cfg channel writes the three
// wave vector harmonics and is always ready; write it only while idle.
// Each particle passes a phase register and a row of CORDIC_STAGES rotation
// cells, then is summed, so ordinary particles are taken one per cycle.
// After a transfer with tlast the input is held off while the set is closed:
// the row drains, the sums are squared and added, and a restoring divider
// yields one quotient bit per cycle. One result transfer leaves on m_axis per
// set. If the receiver stalls, the result waits in the output register and
// the next set streams in and accumulates; only its own close waits for the
// register to empty. Reset clears the sums, the count, the overflow flag and
// the output valid, and sets all harmonics to one.
// ----------------------------------------------------------------------------
module structure_factor_accumulator_unit #(
    parameter int MAX_PARTICLES = sfa_pkg::DEF_MAX_PARTICLES,
    parameter int POSITION_BITS = sfa_pkg::DEF_POSITION_BITS,
    parameter int CORDIC_STAGES = sfa_pkg::DEF_CORDIC_STAGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: pos_x[23:0], pos_y[23:0], pos_z[23:0].
    input  logic [sfa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: structure_factor[29:0], particle_count[13:0],
    // count_overflow, then three zero bits.
    output logic [sfa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfa_pkg::HARM_W-1:0]        cfg_data
);
    import sfa_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
    localparam int SUM_W  = $clog2(MAX_PARTICLES) + UNIT_W;
    localparam int ABS_W  = SUM_W - 1;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int MAG_W  = SQ_W + 1;
    localparam int DIVD_W = MAG_W - FRAC_BITS;
    localparam int PROD_W = TURN_W + HARM_W + 2;

    localparam logic [TURN_W-1:0] PMASK = TURN_W'((64'd1 << POSITION_BITS) - 64'd1);
    localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_PARTICLES);
    localparam logic signed [CX_W-1:0] UNIT_POS = CX_W'(65536);
    localparam logic signed [CX_W-1:0] UNIT_NEG = -UNIT_POS;

    typedef enum logic [2:0] {
        FIN_IDLE,
        FIN_ABS,
        FIN_SQUARE,
        FIN_SUM,
        FIN_START,
        FIN_WAIT,
        FIN_OUT
    } fin_state_t;

    // Configuration
    logic [HARM_W-1:0] harm_x_reg;
    logic [HARM_W-1:0] harm_y_reg;
    logic [HARM_W-1:0] harm_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            harm_x_reg <= HARMONIC_RESET;
            harm_y_reg <= HARMONIC_RESET;
            harm_z_reg <= HARMONIC_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HARMONIC_X: harm_x_reg <= cfg_data;
                REG_HARMONIC_Y: harm_y_reg <= cfg_data;
                REG_HARMONIC_Z: harm_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Phase stage
    logic              in_xfer;
    logic              pending_reg;
    logic [TURN_W-1:0] px;
    logic [TURN_W-1:0] py;
    logic [TURN_W-1:0] pz;
    logic [PROD_W-1:0] phase_sum;
    logic [TURN_W-1:0] turn;
    cordic_lane_t      phase_next;
    cordic_lane_t      phase_reg;
    cordic_lane_t      lane [CORDIC_STAGES + 1];

    assign s_axis_tready = !pending_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign px = TURN_W'(s_axis_tdata[POS_W-1:0]) & PMASK;
    assign py = TURN_W'(s_axis_tdata[2*POS_W-1:POS_W]) & PMASK;
    assign pz = TURN_W'(s_axis_tdata[3*POS_W-1:2*POS_W]) & PMASK;

    assign phase_sum = PROD_W'(harm_x_reg) * PROD_W'(px)
                     + PROD_W'(harm_y_reg) * PROD_W'(py)
                     + PROD_W'(harm_z_reg) * PROD_W'(pz);
    assign turn      = (phase_sum[TURN_W-1:0] & PMASK) << (TURN_W - POSITION_BITS);

    always_comb
    begin
        phase_next.valid = in_xfer;
        phase_next.last  = s_axis_tlast;
        phase_next.quad  = turn[TURN_W-1:TURN_W-2];
        phase_next.x     = CORDIC_X0;
        phase_next.y     = '0;
        phase_next.z     = CZ_W'(turn[TURN_W-3:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    assign lane[0] = phase_reg;

    // Rotation cells
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        sfa_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .lane_in  (lane[i]),
            .lane_out (lane[i+1])
        );
    end

    // Quadrant mapping and accumulation
    cordic_lane_t             tail;
    logic signed [CX_W-1:0]   xs;
    logic signed [CX_W-1:0]   ys;
    logic signed [UNIT_W-1:0] cq;
    logic signed [UNIT_W-1:0] sq;
    logic signed [UNIT_W-1:0] cv;
    logic signed [UNIT_W-1:0] sv;
    logic signed [SUM_W-1:0]  cos_sum_reg;
    logic signed [SUM_W-1:0]  sin_sum_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     ovf_reg;
    logic                     take;
    logic signed [SUM_W-1:0]  cos_total;
    logic signed [SUM_W-1:0]  sin_total;
    logic [CNT_W-1:0]         count_total;
    logic                     ovf_total;

    assign tail = lane[CORDIC_STAGES];
    assign xs   = tail.x >>> UNIT_SHIFT;
    assign ys   = tail.y >>> UNIT_SHIFT;

    always_comb
    begin
        if (xs > UNIT_POS)
            cq = UNIT_W'(UNIT_POS);
        else if (xs < UNIT_NEG)
            cq = UNIT_W'(UNIT_NEG);
        else
            cq = UNIT_W'(xs);
        if (ys > UNIT_POS)
            sq = UNIT_W'(UNIT_POS);
        else if (ys < UNIT_NEG)
            sq = UNIT_W'(UNIT_NEG);
        else
            sq = UNIT_W'(ys);
        case (tail.quad)
            QUAD_I:
            begin
                cv = cq;
                sv = sq;
            end
            QUAD_II:
            begin
                cv = -sq;
                sv = cq;
            end
            QUAD_III:
            begin
                cv = -cq;
                sv = -sq;
            end
            default:
            begin
                cv = sq;
                sv = -cq;
            end
        endcase
    end

    assign take        = count_reg < MAX_COUNT;
    assign cos_total   = take ? cos_sum_reg + SUM_W'(cv) : cos_sum_reg;
    assign sin_total   = take ? sin_sum_reg + SUM_W'(sv) : sin_sum_reg;
    assign count_total = take ? count_reg + 1'b1 : count_reg;
    assign ovf_total   = ovf_reg || !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_sum_reg <= '0;
            sin_sum_reg <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (tail.valid)
        begin
            if (tail.last)
            begin
                cos_sum_reg <= '0;
                sin_sum_reg <= '0;
                count_reg   <= '0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                cos_sum_reg <= cos_total;
                sin_sum_reg <= sin_total;
                count_reg   <= count_total;
                ovf_reg     <= ovf_total;
            end
        end
    end

    // Closing a set
    fin_state_t              state_reg;
    logic signed [SUM_W-1:0] fin_c_reg;
    logic signed [SUM_W-1:0] fin_s_reg;
    logic [CNT_W-1:0]        fin_n_reg;
    logic                    fin_ovf_reg;
    logic [ABS_W-1:0]        abs_c_reg;
    logic [ABS_W-1:0]        abs_s_reg;
    logic [SQ_W-1:0]         sq_c_reg;
    logic [SQ_W-1:0]         sq_s_reg;
    logic [MAG_W-1:0]        mag;
    logic [DIVD_W-1:0]       divd_reg;
    logic [SF_W-1:0]         sf_reg;
    logic                    m_valid_reg;
    logic [OUT_TDATA_W-1:0]  m_data_reg;
    logic                    div_start;
    logic                    div_done;
    logic [DIVD_W-1:0]       div_quot;

    assign mag       = MAG_W'(sq_c_reg) + MAG_W'(sq_s_reg);
    assign div_start = (state_reg == FIN_START);

    sfa_divider #(
        .N_W (DIVD_W),
        .D_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (divd_reg),
        .divisor  (fin_n_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FIN_IDLE;
            pending_reg <= 1'b0;
            fin_c_reg   <= '0;
            fin_s_reg   <= '0;
            fin_n_reg   <= '0;
            fin_ovf_reg <= 1'b0;
            abs_c_reg   <= '0;
            abs_s_reg   <= '0;
            sq_c_reg    <= '0;
            sq_s_reg    <= '0;
            divd_reg    <= '0;
            sf_reg      <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            if (in_xfer && s_axis_tlast)
                pending_reg <= 1'b1;
            if (m_valid_reg && m_axis_tready && (state_reg != FIN_OUT))
                m_valid_reg <= 1'b0;
            case (state_reg)
                FIN_IDLE:
                begin
                    if (tail.valid && tail.last)
                    begin
                        fin_c_reg   <= cos_total;
                        fin_s_reg   <= sin_total;
                        fin_n_reg   <= count_total;
                        fin_ovf_reg <= ovf_total;
                        state_reg   <= FIN_ABS;
                    end
                end
                FIN_ABS:
                begin
                    abs_c_reg <= ABS_W'(fin_c_reg[SUM_W-1] ? -fin_c_reg : fin_c_reg);
                    abs_s_reg <= ABS_W'(fin_s_reg[SUM_W-1] ? -fin_s_reg : fin_s_reg);
                    state_reg <= FIN_SQUARE;
                end
                FIN_SQUARE:
                begin
                    sq_c_reg  <= SQ_W'(abs_c_reg) * SQ_W'(abs_c_reg);
                    sq_s_reg  <= SQ_W'(abs_s_reg) * SQ_W'(abs_s_reg);
                    state_reg <= FIN_SUM;
                end
                FIN_SUM:
                begin
                    divd_reg  <= mag[MAG_W-1:FRAC_BITS];
                    state_reg <= FIN_START;
                end
                FIN_START:
                begin
                    state_reg <= FIN_WAIT;
                end
                FIN_WAIT:
                begin
                    if (div_done)
                    begin
                        sf_reg    <= (fin_n_reg == '0) ? '0 : SF_W'(div_quot);
                        state_reg <= FIN_OUT;
                    end
                end
                FIN_OUT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= OUT_TDATA_W'({fin_ovf_reg,
                                                     PCOUNT_W'(fin_n_reg),
                                                     sf_reg});
                        pending_reg <= 1'b0;
                        state_reg   <= FIN_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= FIN_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

@@ hdl/sfa_checker.sv @@
// ----------------------------------------------------------------------------
// sfa_checker
// Port-level checks on the structure factor unit, bound to the top level.
// ----------------------------------------------------------------------------
module sfa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import sfa_pkg::*;

    a_no_result_in_reset : assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("Result valid during reset.");

    a_result_holds : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result changed or dropped.");

    a_close_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("Input taken while a set is being closed.");

    a_result_after_close : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("Result appeared without a closed set.");

endmodule

bind structure_factor_accumulator_unit sfa_checker u_sfa_checker (.*);
